// File: hdl/pts_pkg.sv
// Package for the priority task scheduler: sizes, codes, state machine type.
// No dependencies.
package pts_pkg;
  localparam int TASKS = 8;
  localparam int SEMAPHORES = 4;
  localparam int PRIORITY_LEVELS = 8;
  localparam int TW = $clog2(TASKS);
  localparam int SW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;

  typedef enum logic [2:0] {
    ST_RUN = 3'd0, ST_WAIT = 3'd1, ST_LOW = 3'd2, ST_HIGH = 3'd3, ST_DONE = 3'd4
  } task_st_t;

  typedef enum logic [2:0] {
    REQ_SCHED = 3'd0, REQ_P = 3'd1, REQ_V = 3'd2, REQ_EXIT = 3'd3, REQ_TICK = 3'd4
  } req_t;

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_NORUN = 2'd1;
  localparam logic [1:0] ERR_SAT = 2'd2;

  typedef enum logic [2:0] {
    FS_IDLE, FS_SCAN, FS_DECIDE, FS_WALK, FS_OUT
  } fsm_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic          start;
    logic          step;
    logic [TW-1:0] idx;
  } scan_ctl_t;
endpackage

// File: hdl/pts_scan.sv
// Compare unit: one task per cycle while stepped, keeps the best high and low candidate.
// Depends on pts_pkg.
module pts_scan import pts_pkg::*; (
  input  logic          clk,
  input  scan_ctl_t     ctl,
  input  task_st_t      st,
  input  logic [2:0]    prio,
  output logic          best_v,
  output logic [TW-1:0] best
);
  logic          hv_r, lv_r;
  logic [TW-1:0] hi_r, li_r;
  logic [3:0]    hp_r, lp_r;
  logic [3:0]    p4;

  assign p4 = {1'b0, prio};

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      hv_r <= 1'b0;
      lv_r <= 1'b0;
      hp_r <= 4'(PRIORITY_LEVELS);
      lp_r <= 4'(PRIORITY_LEVELS);
      hi_r <= '0;
      li_r <= '0;
    end else if (ctl.step) begin
      if (st == ST_HIGH && p4 < hp_r) begin
        hv_r <= 1'b1;
        hp_r <= p4;
        hi_r <= ctl.idx;
      end
      if (st == ST_LOW && p4 < lp_r) begin
        lv_r <= 1'b1;
        lp_r <= p4;
        li_r <= ctl.idx;
      end
    end
  end

  assign best_v = hv_r | lv_r;
  assign best = hv_r ? hi_r : li_r;
endmodule

// File: hdl/priority_task_scheduler_semaphores.sv
// Top level of the priority task scheduler with counting semaphores; needs pts_pkg, pts_scan.
// A schedule word scans every task through the single scan unit, and a blocking P walks the
// wait list when it is not empty. One word is in work at a time and the next is taken in the
// cycle after the result leaves.
// Reset (rst_n low, synchronous) puts all tasks high-ready, counts to one, lists empty, contexts 0.
module priority_task_scheduler_semaphores import pts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_priority_table,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [1:0]  in_sem_index,
  input  logic signed [31:0] in_context_value,
  input  logic        in_slice_expired,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_granted,
  output logic        out_running_valid,
  output logic [2:0]  out_running_task,
  output logic signed [31:0] out_restored_context,
  output logic [1:0]  out_error_code
);
  // Configuration and per-task state.
  logic [23:0]         prio_r;
  task_st_t            tst_r [TASKS];
  logic [TW:0]         link_r [TASKS];
  logic [31:0]         ctx_r [TASKS];
  logic signed [7:0]   cnt_r [SEMAPHORES];
  logic [TW:0]         head_r [SEMAPHORES];
  logic                run_v_r;
  logic [TW-1:0]       run_r;

  // Latched request word.
  req_t                req_r;
  logic [SW-1:0]       sem_r;
  logic [31:0]         ctxin_r;
  logic                exp_r;

  fsm_t                fs_r, fs_nxt;
  logic [TW:0]         cnt_i_r;    // scan index or walk step count
  logic [TW-1:0]       cur_r;      // walk position

  // Result register.
  logic                ov_r, g_r, rv_r;
  logic [TW-1:0]       rt_r;
  logic [31:0]         rc_r;
  logic [1:0]          err_r;

  scan_ctl_t           sctl;
  logic                best_v;
  logic [TW-1:0]       best;

  function automatic logic [2:0] prio_of(input logic [23:0] tbl, input logic [TW-1:0] t);
    prio_of = tbl[3*t +: 3];
  endfunction

  assign sctl.start = (fs_r == FS_IDLE);
  assign sctl.step  = (fs_r == FS_SCAN);
  assign sctl.idx   = cnt_i_r[TW-1:0];

  pts_scan u_scan (
    .clk(clk), .ctl(sctl), .st(tst_r[cnt_i_r[TW-1:0]]),
    .prio(prio_of(prio_r, cnt_i_r[TW-1:0])), .best_v(best_v), .best(best)
  );

  assign in_ready = (fs_r == FS_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_granted = g_r;
  assign out_running_valid = rv_r;
  assign out_running_task = 3'(rt_r);
  assign out_restored_context = rc_r;
  assign out_error_code = err_r;

  // Wait-list walk: the tail is the link whose successor is not a task.
  logic cur_end;
  assign cur_end = link_r[cur_r][TW];

  // Next-state logic.
  always_comb begin
    fs_nxt = fs_r;
    case (fs_r)
      FS_IDLE: begin
        if (in_valid && in_ready) fs_nxt = FS_DECIDE;
      end
      FS_SCAN: begin
        if (cnt_i_r == (TW+1)'(TASKS-1)) fs_nxt = FS_DECIDE;
      end
      FS_DECIDE: begin
        fs_nxt = FS_OUT;
        if (req_r == REQ_SCHED && cnt_i_r == '0) fs_nxt = FS_SCAN;
        if (req_r == REQ_P && run_v_r && cnt_r[sem_r] - 8'sd1 < 0
            && cnt_r[sem_r] != -8'sd128 && !head_r[sem_r][TW]) fs_nxt = FS_WALK;
        if (req_r == REQ_P && run_v_r && cnt_r[sem_r] == -8'sd128
            && !head_r[sem_r][TW]) fs_nxt = FS_WALK;
      end
      FS_WALK: begin
        if (cur_end || cnt_i_r == (TW+1)'(TASKS-1)) fs_nxt = FS_OUT;
      end
      FS_OUT:  fs_nxt = FS_IDLE;
      default: fs_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FS_IDLE;
    end else begin
      fs_r <= fs_nxt;
    end
  end

  // Datapath and state updates.
  logic signed [7:0] c;
  logic              sched_pre;
  assign c = cnt_r[sem_r];
  assign sched_pre = best_v && (!run_v_r ||
                     prio_of(prio_r, best) < prio_of(prio_r, run_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r  <= '0;
      run_v_r <= 1'b0;
      run_r   <= '0;
      ov_r    <= 1'b0;
      cnt_i_r <= '0;
      for (int i = 0; i < TASKS; i++) begin
        tst_r[i]  <= ST_HIGH;
        link_r[i] <= {1'b1, {TW{1'b0}}};
        ctx_r[i]  <= '0;
      end
      for (int s = 0; s < SEMAPHORES; s++) begin
        cnt_r[s]  <= 8'sd1;
        head_r[s] <= {1'b1, {TW{1'b0}}};
      end
    end else begin
      if (cfg_we) prio_r <= cfg_priority_table;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (fs_r)
        FS_IDLE: begin
          cnt_i_r <= '0;
          if (in_valid && in_ready) begin
            req_r   <= req_t'(in_req_type);
            sem_r   <= SW'(32'(in_sem_index) % SEMAPHORES);
            ctxin_r <= in_context_value;
            exp_r   <= in_slice_expired;
            g_r     <= 1'b0;
            err_r   <= ERR_OK;
          end
        end
        FS_SCAN: begin
          cnt_i_r <= cnt_i_r + 1'b1;
        end
        FS_DECIDE: begin
          cur_r   <= head_r[sem_r][TW-1:0];
          cnt_i_r <= '0;
          if (req_r != REQ_SCHED && req_r <= REQ_TICK && !run_v_r) begin
            err_r <= ERR_NORUN;
          end else begin
            case (req_r)
              REQ_SCHED: begin
                if (cnt_i_r != '0 && sched_pre) begin
                  if (run_v_r) begin
                    tst_r[run_r] <= ST_HIGH;
                    ctx_r[run_r] <= ctxin_r;
                  end
                  tst_r[best] <= ST_RUN;
                  run_r   <= best;
                  run_v_r <= 1'b1;
                end
              end
              REQ_P: begin
                if (c == -8'sd128) err_r <= ERR_SAT;
                else cnt_r[sem_r] <= c - 8'sd1;
                if (c != -8'sd128 && c - 8'sd1 >= 0) begin
                  g_r <= 1'b1;
                end else begin
                  tst_r[run_r]  <= ST_WAIT;
                  ctx_r[run_r]  <= ctxin_r;
                  link_r[run_r] <= {1'b1, {TW{1'b0}}};
                  run_v_r       <= 1'b0;
                  if (head_r[sem_r][TW]) head_r[sem_r] <= {1'b0, run_r};
                end
              end
              REQ_V: begin
                if (c == 8'sd127) err_r <= ERR_SAT;
                else cnt_r[sem_r] <= c + 8'sd1;
                if (c == 8'sd127 || c + 8'sd1 > 0) begin
                  g_r <= 1'b1;
                end else begin
                  if (!head_r[sem_r][TW]) begin
                    head_r[sem_r] <= link_r[head_r[sem_r][TW-1:0]];
                    link_r[head_r[sem_r][TW-1:0]] <= {1'b1, {TW{1'b0}}};
                    tst_r[head_r[sem_r][TW-1:0]] <= ST_HIGH;
                  end
                  ctx_r[run_r] <= ctxin_r;
                end
              end
              REQ_EXIT: begin
                tst_r[run_r] <= ST_DONE;
                run_v_r <= 1'b0;
              end
              REQ_TICK: begin
                if (!exp_r) begin
                  g_r <= 1'b1;
                end else begin
                  tst_r[run_r] <= ST_LOW;
                  ctx_r[run_r] <= ctxin_r;
                  run_v_r <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        FS_WALK: begin
          // The blocked task (old run_r) goes behind the tail.
          if (cur_end || cnt_i_r == (TW+1)'(TASKS-1)) begin
            link_r[cur_r] <= {1'b0, run_r};
          end else begin
            cur_r   <= link_r[cur_r][TW-1:0];
            cnt_i_r <= cnt_i_r + 1'b1;
          end
        end
        FS_OUT: begin
          ov_r  <= 1'b1;
          rv_r  <= run_v_r;
          rt_r  <= run_v_r ? run_r : '0;
          rc_r  <= (req_r == REQ_SCHED && run_v_r) ? ctx_r[run_r] : '0;
        end
        default: ;
      endcase
    end
  end
endmodule

// File: hdl/pts_checker.sv
// Port-level checker for the scheduler, bound to the top level.
// Depends on pts_pkg and the top level's ports.
module pts_port_checker import pts_pkg::*; (
  input logic clk, rst_n, in_valid, in_ready, out_valid, out_ready,
  input logic out_running_valid, input logic [2:0] out_running_task,
  input logic [1:0] out_error_code
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while word pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running_valid |-> out_running_task == 3'd0)
    else $error("task index without running task");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code <= ERR_SAT) else $error("bad error code");
endmodule

bind priority_task_scheduler_semaphores pts_port_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_running_valid(out_running_valid), .out_running_task(out_running_task),
  .out_error_code(out_error_code)
);

// File: test/pts_checker.sv
// Checker for the priority task scheduler: watches both channels, predicts each result word
// from its own copy of the scheduler state and compares. Depends on pts_pkg.
module pts_checker import pts_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_priority_table,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [1:0]         in_sem_index,
  input  logic signed [31:0] in_context_value,
  input  logic               in_slice_expired,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_granted,
  input  logic               out_running_valid,
  input  logic [2:0]         out_running_task,
  input  logic signed [31:0] out_restored_context,
  input  logic [1:0]         out_error_code,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] NO_TASK = 4'd15;

  typedef struct packed {
    logic        granted;
    logic        run_valid;
    logic [2:0]  run_task;
    logic [31:0] restored;
    logic [1:0]  err;
  } sched_answer_t;

  logic [23:0]       prio_tbl;
  task_st_t          tstate [TASKS];
  logic [3:0]        link [TASKS];
  logic [31:0]       ctx_store [TASKS];
  int                count [SEMAPHORES];
  logic [3:0]        head [SEMAPHORES];
  logic [3:0]        running;
  sched_answer_t     answers [$];

  function automatic logic [2:0] prio(input logic [3:0] t);
    return prio_tbl[3*t +: 3];
  endfunction

  function automatic logic [3:0] best_ready();
    logic [3:0] best;
    int bp;
    best = NO_TASK;
    bp = PRIORITY_LEVELS;
    for (int i = 0; i < TASKS; i++)
      if (tstate[i] == ST_HIGH && prio(4'(i)) < bp) begin
        bp = prio(4'(i));
        best = 4'(i);
      end
    if (best != NO_TASK) return best;
    for (int i = 0; i < TASKS; i++)
      if (tstate[i] == ST_LOW && prio(4'(i)) < bp) begin
        bp = prio(4'(i));
        best = 4'(i);
      end
    return best;
  endfunction

  // Appends a task at the tail of a semaphore's wait list.
  task automatic append_waiter(input int s, input logic [3:0] t);
    logic [3:0] cur;
    cur = head[s];
    link[t] = NO_TASK;
    if (cur >= TASKS) begin
      head[s] = t;
      return;
    end
    for (int n = 0; n < TASKS; n++) begin
      if (link[cur] >= TASKS) break;
      cur = link[cur];
    end
    link[cur] = t;
  endtask

  task automatic predict_answer(input logic [2:0] rq, input logic [1:0] si,
                                input logic [31:0] cv, input logic ex);
    sched_answer_t a;
    logic [3:0] run, nx, h;
    logic have;
    int s;
    a = '0;
    run = running;
    have = run < TASKS;
    s = si % SEMAPHORES;
    if (rq >= REQ_P && rq <= REQ_TICK && !have) begin
      a.err = ERR_NORUN;
    end else if (rq == REQ_SCHED) begin
      nx = best_ready();
      if (nx < TASKS) begin
        if (!have) begin
          tstate[nx] = ST_RUN;
          running = nx;
        end else if (prio(nx) < prio(run)) begin
          tstate[run] = ST_HIGH;
          ctx_store[run] = cv;
          tstate[nx] = ST_RUN;
          running = nx;
        end
      end
      if (running < TASKS) a.restored = ctx_store[running];
    end else if (rq == REQ_P) begin
      if (count[s] <= -128) a.err = ERR_SAT;
      else count[s]--;
      if (count[s] >= 0) begin
        a.granted = 1'b1;
      end else begin
        tstate[run] = ST_WAIT;
        append_waiter(s, run);
        ctx_store[run] = cv;
        running = NO_TASK;
      end
    end else if (rq == REQ_V) begin
      if (count[s] >= 127) a.err = ERR_SAT;
      else count[s]++;
      if (count[s] > 0) begin
        a.granted = 1'b1;
      end else begin
        h = head[s];
        if (h < TASKS) begin
          head[s] = link[h];
          link[h] = NO_TASK;
          tstate[h] = ST_HIGH;
        end
        ctx_store[run] = cv;
      end
    end else if (rq == REQ_EXIT) begin
      tstate[run] = ST_DONE;
      running = NO_TASK;
    end else if (rq == REQ_TICK) begin
      if (!ex) begin
        a.granted = 1'b1;
      end else begin
        tstate[run] = ST_LOW;
        ctx_store[run] = cv;
        running = NO_TASK;
      end
    end
    a.run_valid = running < TASKS;
    a.run_task = (running < TASKS) ? running[2:0] : 3'd0;
    answers.push_back(a);
  endtask

  always @(posedge clk) begin
    sched_answer_t want, got;
    if (!rst_n) begin
      prio_tbl = '0;
      for (int i = 0; i < TASKS; i++) begin
        tstate[i] = ST_HIGH;
        link[i] = NO_TASK;
        ctx_store[i] = '0;
      end
      for (int i = 0; i < SEMAPHORES; i++) begin
        count[i] = 1;
        head[i] = NO_TASK;
      end
      running = NO_TASK;
      answers.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_we) prio_tbl = cfg_priority_table;
      if (out_valid && out_ready) begin
        got = '{out_granted, out_running_valid, out_running_task,
                out_restored_context, out_error_code};
        if (answers.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count++;
        end else begin
          want = answers.pop_front();
          if (got.granted !== want.granted) begin
            $display("%0t: granted expected %0d actual %0d", $time, want.granted, got.granted);
            fail_count++;
          end
          if (got.run_valid !== want.run_valid) begin
            $display("%0t: running_valid expected %0d actual %0d", $time,
                     want.run_valid, got.run_valid);
            fail_count++;
          end
          if (got.run_task !== want.run_task) begin
            $display("%0t: running_task expected %0d actual %0d", $time,
                     want.run_task, got.run_task);
            fail_count++;
          end
          if (got.restored !== want.restored) begin
            $display("%0t: restored_context expected %h actual %h", $time,
                     want.restored, got.restored);
            fail_count++;
          end
          if (got.err !== want.err) begin
            $display("%0t: error_code expected %0d actual %0d", $time, want.err, got.err);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        predict_answer(in_req_type, in_sem_index, in_context_value, in_slice_expired);
      pending = answers.size();
    end
  end
endmodule

// File: test/tb.sv
// Top of the scheduler testbench: clock, reset, priority-table writes and request stimulus.
// Depends on pts_pkg, pts_checker and the scheduler RTL.
module tb import pts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [23:0]        cfg_priority_table;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_req_type;
  logic [1:0]         in_sem_index;
  logic signed [31:0] in_context_value;
  logic               in_slice_expired;
  logic               out_valid;
  logic               out_ready;
  logic               out_granted;
  logic               out_running_valid;
  logic [2:0]         out_running_task;
  logic signed [31:0] out_restored_context;
  logic [1:0]         out_error_code;
  int                 fail_count;
  int                 pending;
  // When set, the receiver never stalls and the sender never idles.
  logic               no_gaps;

  priority_task_scheduler_semaphores u_top (.*);

  pts_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random, about 37 percent of the time, except in the no-gap stretch.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= no_gaps || ($urandom_range(99) >= 37);
  end

  // Presents one request word and holds it until the block takes it. Random
  // idle cycles are put in front of the word unless the no-gap stretch is on.
  // Valid stays up after the word is taken; an idle gap or a drain drops it.
  task automatic send_word(input logic [2:0] rq, input logic [1:0] si,
                           input logic [31:0] cv, input logic ex);
    if (!no_gaps && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    in_valid <= 1'b1;
    in_req_type <= rq;
    in_sem_index <= si;
    in_context_value <= cv;
    in_slice_expired <= ex;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits until every expected word has arrived, then lets the longest
  // request latency pass so the block is idle before a table write.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TASKS + 8) @(posedge clk);
  endtask

  task automatic write_table(input logic [23:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_priority_table <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly schedule, P and V, with exits and ticks to move tasks through
  // every state; a few unknown request codes are mixed in.
  task automatic send_random_word();
    int r;
    logic [2:0] rq;
    r = $urandom_range(99);
    if (r < 30) rq = REQ_SCHED;
    else if (r < 55) rq = REQ_P;
    else if (r < 78) rq = REQ_V;
    else if (r < 84) rq = REQ_EXIT;
    else if (r < 96) rq = REQ_TICK;
    else rq = 3'($urandom_range(7, 5));
    send_word(rq, 2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_priority_table = '0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_sem_index = '0;
    in_context_value = '0;
    in_slice_expired = 1'b0;
    no_gaps = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. With no task running, P, V, exit and tick all answer
    // the no-running-task error; unknown codes change nothing and answer without an error.
    write_table(24'hFAC688);
    send_word(REQ_P, 2'd0, 32'h7FFFFFFF, 1'b0);
    send_word(REQ_V, 2'd1, 32'h80000000, 1'b0);
    send_word(REQ_EXIT, 2'd2, 32'h0, 1'b0);
    send_word(REQ_TICK, 2'd3, 32'hFFFFFFFF, 1'b1);
    send_word(3'd7, 2'd3, 32'h0, 1'b1);
    send_word(REQ_SCHED, 2'd0, 32'h12345678, 1'b0);
    // The first P takes the count to zero, the next blocks and saves the context.
    send_word(REQ_P, 2'd0, 32'h11111111, 1'b0);
    send_word(REQ_P, 2'd0, 32'h22222222, 1'b0);
    send_word(REQ_SCHED, 2'd0, 32'h33333333, 1'b0);
    send_word(REQ_P, 2'd0, 32'h44444444, 1'b0);
    send_word(REQ_SCHED, 2'd0, 32'h55555555, 1'b0);
    send_word(REQ_V, 2'd0, 32'h66666666, 1'b0);
    send_word(REQ_V, 2'd0, 32'h77777777, 1'b0);
    send_word(REQ_TICK, 2'd0, 32'h0, 1'b0);
    send_word(REQ_TICK, 2'd0, 32'hDEADBEEF, 1'b1);
    send_word(REQ_SCHED, 2'd0, 32'h0, 1'b0);
    send_word(REQ_EXIT, 2'd0, 32'h0, 1'b0);
    send_word(REQ_SCHED, 2'd0, 32'h0, 1'b0);
    // V to the upper limit saturates at 127.
    for (int i = 0; i < 130; i++) send_word(REQ_V, 2'd3, $urandom, 1'b0);

    // Random part over several priority tables, the extremes among them.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_table(24'h000000);
        1: write_table(24'hFFFFFF);
        default: write_table(24'($urandom));
      endcase
      // Reset-free refill in the first phase: V words on semaphore 2, each followed by a
      // schedule, drive its count up to the upper limit of 127 before the random mix.
      if (phase == 0) begin
        send_word(REQ_SCHED, 2'd0, 32'h0, 1'b0);
        for (int i = 0; i < 140; i++) begin
          send_word(REQ_V, 2'd2, $urandom, 1'b0);
          send_word(REQ_SCHED, 2'd0, $urandom, 1'b0);
        end
      end
      if (phase == 3) no_gaps = 1'b1;
      for (int i = 0; i < 220; i++) send_random_word();
      no_gaps = 1'b0;
      // The sender holds off once until every answer is in.
      if (phase == 2) drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: files.f
hdl/pts_pkg.sv
hdl/pts_scan.sv
hdl/priority_task_scheduler_semaphores.sv
hdl/pts_checker.sv
test/pts_checker.sv
test/tb.sv
